FILE: sv/gbfp_pkg.sv
package gbfp_pkg;

    localparam int unsigned DEFAULT_FRAME_LIMIT = 128;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] FIX_3D      = 8'h03;

    localparam int unsigned CAPTURE_DEPTH = 28;
    localparam int unsigned CAP_IDX_W     = $clog2(CAPTURE_DEPTH);
    localparam int unsigned HEADER_BYTES  = 6;

    localparam logic [15:0] CID_ACK    = 16'h0501;
    localparam logic [15:0] CID_NAK    = 16'h0500;
    localparam logic [15:0] CID_POSLLH = 16'h0102;
    localparam logic [15:0] CID_STATUS = 16'h0103;
    localparam logic [15:0] CID_VELNED = 16'h0112;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [2:0] KIND_ACK      = 3'd0;
    localparam logic [2:0] KIND_NAK      = 3'd1;
    localparam logic [2:0] KIND_POSITION = 3'd2;
    localparam logic [2:0] KIND_STATUS   = 3'd3;
    localparam logic [2:0] KIND_VELOCITY = 3'd4;
    localparam logic [2:0] KIND_OTHER    = 3'd5;

    typedef logic [CAPTURE_DEPTH-1:0][7:0] capture_t;

endpackage

FILE: sv/gnss_binary_frame_parser_unit.sv
// A result appears on m_* in the cycle after the transfer of the byte that ends its frame.
// Throughput: one byte per cycle while s_ready is high; every byte is parsed in the cycle it
// is taken, the running Fletcher sum and the decode sit between the parser state and the result
// register. s_ready drops only while a result waits on m_* and m_ready is low.
// Reset (aresetn low, synchronous): hunt for the first sync byte, sums, length, class/id and
// stored fix type cleared, result register empty.
module gnss_binary_frame_parser_unit
    import gbfp_pkg::*;
#(
    parameter int unsigned FRAME_LIMIT = DEFAULT_FRAME_LIMIT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_frame_status,
    output logic [2:0]  m_message_kind,
    output logic [15:0] m_class_and_id,
    output logic [31:0] m_word_a,
    output logic [31:0] m_word_b,
    output logic [31:0] m_word_c,
    output logic [31:0] m_status_bytes,
    output logic        m_fresh_velocity
);

    localparam int unsigned POS_W = $clog2(FRAME_LIMIT + 1);
    localparam int unsigned CMP_W = (POS_W > 16) ? POS_W : 16;

    localparam logic [3:0] PH_SYNC0 = 4'd0;
    localparam logic [3:0] PH_SYNC1 = 4'd1;
    localparam logic [3:0] PH_CLASS = 4'd2;
    localparam logic [3:0] PH_ID    = 4'd3;
    localparam logic [3:0] PH_LEN0  = 4'd4;
    localparam logic [3:0] PH_LEN1  = 4'd5;
    localparam logic [3:0] PH_LOAD  = 4'd6;
    localparam logic [3:0] PH_CKA   = 4'd7;
    localparam logic [3:0] PH_CKB   = 4'd8;

    logic [3:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;
    logic [7:0]       class_reg, class_next;
    logic [7:0]       id_reg, id_next;
    logic [7:0]       rx_sum_a_reg, rx_sum_a_next;
    capture_t         cap_reg, cap_next;
    logic [7:0]       fix_reg, fix_next;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [2:0]       kind_reg, kind_next;
    logic [15:0]      cid_reg, cid_next;
    logic [31:0]      word_a_reg, word_a_next;
    logic [31:0]      word_b_reg, word_b_next;
    logic [31:0]      word_c_reg, word_c_next;
    logic [31:0]      stat_reg, stat_next;
    logic             fresh_reg, fresh_next;

    logic             take;
    logic             res_fire;
    logic             bump;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] idx_inc;
    logic [7:0]       sa_add;
    logic [7:0]       sb_add;
    logic [15:0]      len_full;
    logic [15:0]      cid_cur;

    function automatic logic [31:0] le32(input capture_t c, input int unsigned at);
        return {c[at+3], c[at+2], c[at+1], c[at]};
    endfunction

    assign s_ready  = !m_valid_reg || m_ready;
    assign take     = s_valid && s_ready;
    assign pos_inc  = pos_reg + 1'b1;
    assign idx      = pos_reg - POS_W'(HEADER_BYTES);
    assign idx_inc  = idx + 1'b1;
    assign sa_add   = sum_a_reg + s_rx_byte;
    assign sb_add   = sum_b_reg + sa_add;
    assign len_full = {s_rx_byte, len_reg[7:0]};
    assign cid_cur  = {class_reg, id_reg};

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        class_next    = class_reg;
        id_next       = id_reg;
        rx_sum_a_next = rx_sum_a_reg;
        cap_next      = cap_reg;
        fix_next      = fix_reg;
        res_fire      = 1'b0;
        bump          = 1'b0;
        status_next   = ST_OK;
        kind_next     = KIND_OTHER;
        cid_next      = cid_cur;
        word_a_next   = '0;
        word_b_next   = '0;
        word_c_next   = '0;
        stat_next     = '0;
        fresh_next    = 1'b0;

        if (take) begin
            case (phase_reg)
                PH_SYNC1: begin
                    if (s_rx_byte == SYNC_SECOND) begin
                        pos_next   = POS_W'(2);
                        phase_next = PH_CLASS;
                    end else if (s_rx_byte == SYNC_FIRST) begin
                        cap_next   = '0;
                        sum_a_next = '0;
                        sum_b_next = '0;
                        len_next   = '0;
                        pos_next   = POS_W'(1);
                        phase_next = PH_SYNC1;
                    end else begin
                        phase_next = PH_SYNC0;
                        pos_next   = '0;
                    end
                end
                PH_CKB: begin
                    res_fire   = 1'b1;
                    phase_next = PH_SYNC0;
                    pos_next   = '0;
                    if (rx_sum_a_reg != sum_a_reg || s_rx_byte != sum_b_reg) begin
                        status_next = ST_CHECKSUM;
                    end else begin
                        case (cid_cur)
                            CID_ACK, CID_NAK: begin
                                kind_next   = (cid_cur == CID_ACK) ? KIND_ACK : KIND_NAK;
                                word_a_next = {16'd0, cap_reg[0], cap_reg[1]};
                            end
                            CID_POSLLH: begin
                                kind_next   = KIND_POSITION;
                                word_a_next = le32(cap_reg, 4);
                                word_b_next = le32(cap_reg, 8);
                                word_c_next = le32(cap_reg, 12);
                            end
                            CID_STATUS: begin
                                kind_next   = KIND_STATUS;
                                fix_next    = cap_reg[4];
                                stat_next   = le32(cap_reg, 4);
                                word_a_next = le32(cap_reg, 8);
                                word_b_next = le32(cap_reg, 12);
                            end
                            CID_VELNED: begin
                                kind_next   = KIND_VELOCITY;
                                word_a_next = le32(cap_reg, 16);
                                word_b_next = le32(cap_reg, 24);
                                fresh_next  = (fix_reg == FIX_3D);
                            end
                            default: begin
                                status_next = ST_UNKNOWN;
                            end
                        endcase
                    end
                end
                PH_CLASS: begin
                    class_next = s_rx_byte;
                    sum_a_next = sa_add;
                    sum_b_next = sb_add;
                    phase_next = PH_ID;
                    bump       = 1'b1;
                end
                PH_ID: begin
                    id_next    = s_rx_byte;
                    sum_a_next = sa_add;
                    sum_b_next = sb_add;
                    phase_next = PH_LEN0;
                    bump       = 1'b1;
                end
                PH_LEN0: begin
                    len_next   = {8'd0, s_rx_byte};
                    sum_a_next = sa_add;
                    sum_b_next = sb_add;
                    phase_next = PH_LEN1;
                    bump       = 1'b1;
                end
                PH_LEN1: begin
                    len_next   = len_full;
                    sum_a_next = sa_add;
                    sum_b_next = sb_add;
                    phase_next = (len_full == 16'd0) ? PH_CKA : PH_LOAD;
                    bump       = 1'b1;
                end
                PH_LOAD: begin
                    // bytes past the capture window are summed only
                    if (idx < POS_W'(CAPTURE_DEPTH)) begin
                        cap_next[idx[CAP_IDX_W-1:0]] = s_rx_byte;
                    end
                    sum_a_next = sa_add;
                    sum_b_next = sb_add;
                    if (CMP_W'(idx_inc) >= CMP_W'(len_reg)) begin
                        phase_next = PH_CKA;
                    end
                    bump = 1'b1;
                end
                PH_CKA: begin
                    rx_sum_a_next = s_rx_byte;
                    phase_next    = PH_CKB;
                    bump          = 1'b1;
                end
                default: begin
                    if (s_rx_byte == SYNC_FIRST) begin
                        cap_next   = '0;
                        sum_a_next = '0;
                        sum_b_next = '0;
                        len_next   = '0;
                        pos_next   = POS_W'(1);
                        phase_next = PH_SYNC1;
                    end else begin
                        phase_next = PH_SYNC0;
                        pos_next   = '0;
                    end
                end
            endcase

            if (bump) begin
                pos_next = pos_inc;
                // drop an overlong frame and report it
                if (pos_inc >= POS_W'(FRAME_LIMIT)) begin
                    res_fire    = 1'b1;
                    status_next = ST_OVERFLOW;
                    kind_next   = KIND_OTHER;
                    cid_next    = {class_next, id_next};
                    phase_next  = PH_SYNC0;
                    pos_next    = '0;
                end
            end
        end

        if (res_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SYNC0;
            pos_reg      <= '0;
            len_reg      <= '0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
            class_reg    <= '0;
            id_reg       <= '0;
            rx_sum_a_reg <= '0;
            fix_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            class_reg    <= class_next;
            id_reg       <= id_next;
            rx_sum_a_reg <= rx_sum_a_next;
            fix_reg      <= fix_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cap_reg <= cap_next;
        if (res_fire) begin
            status_reg <= status_next;
            kind_reg   <= kind_next;
            cid_reg    <= cid_next;
            word_a_reg <= word_a_next;
            word_b_reg <= word_b_next;
            word_c_reg <= word_c_next;
            stat_reg   <= stat_next;
            fresh_reg  <= fresh_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_status   = status_reg;
    assign m_message_kind   = kind_reg;
    assign m_class_and_id   = cid_reg;
    assign m_word_a         = word_a_reg;
    assign m_word_b         = word_b_reg;
    assign m_word_c         = word_c_reg;
    assign m_status_bytes   = stat_reg;
    assign m_fresh_velocity = fresh_reg;

endmodule

FILE: sv/gbfp_checker.sv
module gbfp_checker
    import gbfp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_frame_status,
    input logic [2:0]  m_message_kind,
    input logic [15:0] m_class_and_id,
    input logic [31:0] m_word_a,
    input logic [31:0] m_word_b,
    input logic [31:0] m_word_c,
    input logic [31:0] m_status_bytes,
    input logic        m_fresh_velocity
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_status) && $stable(m_message_kind)
            && $stable(m_class_and_id) && $stable(m_word_a) && $stable(m_word_b))
        else $error("stalled result changed");

    // input stalls only behind a waiting result
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    // failed frames carry no decoded content
    a_fail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_status != ST_OK |-> m_message_kind == KIND_OTHER
            && m_word_a == 32'd0 && m_word_b == 32'd0 && m_word_c == 32'd0
            && m_status_bytes == 32'd0 && !m_fresh_velocity)
        else $error("failed frame carries decoded fields");

    a_fresh_velocity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fresh_velocity |-> m_frame_status == ST_OK
            && m_message_kind == KIND_VELOCITY && m_class_and_id == CID_VELNED)
        else $error("fresh flag on a non-velocity result");

endmodule

bind gnss_binary_frame_parser_unit gbfp_checker u_gbfp_checker (.*);
